// File: hw/rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SDSI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define SDSI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: hw/rtl/sdsi_pkg.sv
`default_nettype none
package sdsi_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RETRY_LIMIT  = 3'd0,
    CFG_RETRY_DELAY  = 3'd1,
    CFG_SETTLE_DELAY = 3'd2,
    CFG_WAKE_DUMMY   = 3'd3,
    CFG_BLOCK_LENGTH = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0]  retry_limit;
    logic [9:0]  retry_delay_ms;
    logic [7:0]  settle_delay_ms;
    logic [4:0]  wake_dummy_bytes;
    logic [11:0] block_length;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    retry_limit:      4'd10,
    retry_delay_ms:   10'd100,
    settle_delay_ms:  8'd10,
    wake_dummy_bytes: 5'd10,
    block_length:     12'd512
  };

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RESET    = 3'd1,
    PH_OCR      = 3'd2,
    PH_IFCOND   = 3'd3,
    PH_ACMD_HCS = 3'd4,
    PH_ACMD     = 3'd5,
    PH_CMD1     = 3'd6,
    PH_BLKLEN   = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_IDLE     = 3'd1,
    ST_VERSION     = 3'd2,
    ST_INIT_FAIL   = 3'd3,
    ST_BLKLEN_FAIL = 3'd4
  } status_t;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_RESP  = 1'b1;

  localparam logic [7:0]  R1_READY     = 8'h00;
  localparam logic [7:0]  R1_IDLE      = 8'h01;
  localparam logic [7:0]  R1_NONE      = 8'hFF;
  localparam logic [31:0] IF_COND_ARG  = 32'h0000_01AA;
  localparam logic [31:0] HCS_ARG      = 32'h4000_0000;
  localparam int unsigned OCR_CCS_BIT  = 30;

  localparam logic [5:0] CMD_GO_IDLE  = 6'd0;
  localparam logic [5:0] CMD_SEND_OP  = 6'd1;
  localparam logic [5:0] CMD_IF_COND  = 6'd8;
  localparam logic [5:0] CMD_BLOCKLEN = 6'd16;
  localparam logic [5:0] CMD_APP_OP   = 6'd41;
  localparam logic [5:0] CMD_READ_OCR = 6'd58;

  typedef struct packed {
    logic        app_cmd;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [7:0]  cmd_crc;
  } cmd_t;

  typedef struct packed {
    logic [4:0]  dummy_bytes;
    logic [9:0]  wait_ms;
    logic        send_cmd;
    cmd_t        cmd;
    logic        done_res;
    status_t     status;
  } res_t;

  function automatic cmd_t phase_cmd(phase_t ph, logic [11:0] blen);
    cmd_t c;
    c = '0;
    unique case (ph)
      PH_RESET:    c = '{1'b0, CMD_GO_IDLE,  32'h0,       8'h95};
      PH_OCR:      c = '{1'b0, CMD_READ_OCR, 32'h0,       8'hFD};
      PH_IFCOND:   c = '{1'b0, CMD_IF_COND,  IF_COND_ARG, 8'h87};
      PH_ACMD_HCS: c = '{1'b1, CMD_APP_OP,   HCS_ARG,     8'h65};
      PH_ACMD:     c = '{1'b1, CMD_APP_OP,   32'h0,       8'hE5};
      PH_CMD1:     c = '{1'b0, CMD_SEND_OP,  32'h0,       8'hF9};
      PH_BLKLEN:   c = '{1'b0, CMD_BLOCKLEN, {20'h0, blen}, 8'hFF};
      PH_IDLE:     c = '0;
      default:     c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/sdsi_cfg.sv
`default_nettype none
module sdsi_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         wr_en,
  input  wire logic [sdsi_pkg::CfgIdxW-1:0]  wr_idx,
  input  wire logic [sdsi_pkg::CfgDataW-1:0] wr_data,
  output sdsi_pkg::cfg_t                    cfg
);
  import sdsi_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_idx)
        CFG_RETRY_LIMIT:  cfg_nxt.retry_limit      = wr_data[3:0];
        CFG_RETRY_DELAY:  cfg_nxt.retry_delay_ms   = wr_data[9:0];
        CFG_SETTLE_DELAY: cfg_nxt.settle_delay_ms  = wr_data[7:0];
        CFG_WAKE_DUMMY:   cfg_nxt.wake_dummy_bytes = wr_data[4:0];
        CFG_BLOCK_LENGTH: cfg_nxt.block_length     = wr_data[11:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// File: hw/rtl/sdsi_step.sv
`default_nettype none
module sdsi_step (
  input  wire logic           func,
  input  wire logic [7:0]     r1_byte,
  input  wire logic [31:0]    trailer_word,
  input  wire sdsi_pkg::cfg_t   cfg,
  input  wire sdsi_pkg::phase_t phase,
  input  wire logic [3:0]     tries,
  input  wire logic           needs_blocklen,
  output sdsi_pkg::phase_t    phase_nxt,
  output logic [3:0]          tries_nxt,
  output logic                needs_blocklen_nxt,
  output sdsi_pkg::res_t      res
);
  import sdsi_pkg::*;

  logic more;
  logic r1_ready;
  logic r1_idle;
  logic is_start;

  assign more     = tries < cfg.retry_limit;
  assign r1_ready = r1_byte == R1_READY;
  assign r1_idle  = r1_byte == R1_IDLE;
  assign is_start = func == FUNC_START;

  // next state
  always_comb begin
    phase_nxt          = phase;
    tries_nxt          = tries;
    needs_blocklen_nxt = needs_blocklen;
    if (is_start) begin
      phase_nxt          = PH_RESET;
      tries_nxt          = 4'd1;
      needs_blocklen_nxt = 1'b1;
    end else begin
      unique case (phase)
        PH_RESET: begin
          priority if (r1_idle) begin
            phase_nxt = PH_OCR;
            tries_nxt = 4'd1;
          end else if (more) begin
            tries_nxt = tries + 4'd1;
          end else begin
            phase_nxt = PH_IDLE;
            tries_nxt = 4'd0;
          end
        end
        PH_OCR: begin
          needs_blocklen_nxt = !trailer_word[OCR_CCS_BIT];
          phase_nxt          = PH_IFCOND;
          tries_nxt          = 4'd1;
        end
        PH_IFCOND: begin
          priority if (r1_byte == R1_NONE) begin
            phase_nxt = PH_IDLE;
            tries_nxt = 4'd0;
          end else if (r1_idle && trailer_word == IF_COND_ARG) begin
            phase_nxt = PH_ACMD_HCS;
            tries_nxt = 4'd1;
          end else begin
            phase_nxt = PH_ACMD;
            tries_nxt = 4'd1;
          end
        end
        PH_ACMD_HCS, PH_ACMD, PH_CMD1: begin
          priority if (r1_ready) begin
            phase_nxt = needs_blocklen ? PH_BLKLEN : PH_IDLE;
            tries_nxt = needs_blocklen ? 4'd1 : 4'd0;
          end else if (more) begin
            tries_nxt = tries + 4'd1;
          end else if (phase == PH_CMD1) begin
            phase_nxt = PH_IDLE;
            tries_nxt = 4'd0;
          end else begin
            phase_nxt = (phase == PH_ACMD_HCS) ? PH_ACMD : PH_CMD1;
            tries_nxt = 4'd1;
          end
        end
        PH_BLKLEN: begin
          phase_nxt = PH_IDLE;
          tries_nxt = 4'd0;
        end
        PH_IDLE: begin
          phase_nxt = phase;
        end
        default: phase_nxt = phase;
      endcase
    end
  end

  // result: a command always belongs to the phase being entered or retried
  always_comb begin
    res          = '0;
    res.send_cmd = phase_nxt != PH_IDLE;
    if (res.send_cmd) begin
      res.cmd = phase_cmd(phase_nxt, cfg.block_length);
    end
    if (is_start) begin
      res.dummy_bytes = cfg.wake_dummy_bytes;
      res.wait_ms     = {2'b00, cfg.settle_delay_ms};
    end else if (res.send_cmd &&
                 (((phase == PH_RESET) && !r1_idle) ||
                  (((phase == PH_ACMD_HCS) || (phase == PH_ACMD) ||
                    (phase == PH_CMD1)) && !r1_ready))) begin
      res.wait_ms = cfg.retry_delay_ms;
    end
    if (!is_start && phase != PH_IDLE && phase_nxt == PH_IDLE) begin
      res.done_res = 1'b1;
      unique case (phase)
        PH_RESET:  res.status = ST_NO_IDLE;
        PH_IFCOND: res.status = ST_VERSION;
        PH_CMD1:   res.status = r1_ready ? ST_OK : ST_INIT_FAIL;
        PH_BLKLEN: res.status = r1_ready ? ST_OK : ST_BLKLEN_FAIL;
        default:   res.status = ST_OK;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sd_spi_init_sequencer_top.sv
`default_nettype none
// SD card SPI-mode bring-up sequencer.
// in_ channel: one request per start or card response. tuser[0] is func
// (0 start, 1 response); tdata carries the R1 byte and the 32-bit trailer.
// out_ channel: one result per request, either the next command to send
// (tuser[0] send_cmd) with its wake-up byte count and wait, or the final
// status (tuser[1] done_res); a response while idle gets neither.
// cfg_ channel: register writes, always ready. The user must write only while
// no request is in flight; the block itself does not enforce this.
// The result reaches out_tvalid through the input register, then the result
// register. Throughput is one request per cycle while out_tready is high: the
// phase, tries and capacity flag update in the same cycle the result is latched.
// A stalled out_tready holds the result; one more request waits in the
// input register, after which in_tready drops.
// Reset (rst_n low, synchronous) loads the register defaults, returns to
// idle and empties both stages.
module sd_spi_init_sequencer_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [39:0]                   in_tdata,   // r1_byte, trailer_word
  input  wire logic [0:0]                    in_tuser,   // func
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // dummy_bytes, wait_ms, app_cmd, cmd_index, cmd_arg, cmd_crc, status
  output logic [71:0]                        out_tdata,
  output logic [1:0]                         out_tuser,  // send_cmd, done_res
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [sdsi_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [sdsi_pkg::CfgDataW-1:0] cfg_data
);
  import sdsi_pkg::*;

  cfg_t        cfg;
  logic        in_vld_r;
  logic        in_func_r;
  logic [7:0]  in_r1_r;
  logic [31:0] in_trl_r;
  logic        adv;

  phase_t      phase_r;
  phase_t      phase_nxt;
  logic [3:0]  tries_r;
  logic [3:0]  tries_nxt;
  logic        needs_r;
  logic        needs_nxt;

  res_t        res_nxt;
  res_t        res_r;
  logic        out_vld_r;

  assign cfg_ready = 1'b1;

  sdsi_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid & cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_func_r <= in_tuser[0];
      in_r1_r   <= in_tdata[7:0];
      in_trl_r  <= in_tdata[39:8];
    end
  end

  sdsi_step u_step (
    .func               (in_func_r),
    .r1_byte            (in_r1_r),
    .trailer_word       (in_trl_r),
    .cfg                (cfg),
    .phase              (phase_r),
    .tries              (tries_r),
    .needs_blocklen     (needs_r),
    .phase_nxt          (phase_nxt),
    .tries_nxt          (tries_nxt),
    .needs_blocklen_nxt (needs_nxt),
    .res                (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tries_r <= 4'd0;
      needs_r <= 1'b1;
    end else if (adv) begin
      phase_r <= phase_nxt;
      tries_r <= tries_nxt;
      needs_r <= needs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'b0, res_r.status, res_r.cmd.cmd_crc, res_r.cmd.cmd_arg,
                       res_r.cmd.cmd_index, res_r.cmd.app_cmd, res_r.wait_ms,
                       res_r.dummy_bytes};
  assign out_tuser  = {res_r.done_res, res_r.send_cmd};

endmodule
`default_nettype wire

// File: hw/rtl/sdsi_chk.sv
`default_nettype none
`include "assert_macros.svh"
module sdsi_chk (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tvalid,
  input wire logic                          in_tready,
  input wire logic [39:0]                   in_tdata,
  input wire logic [0:0]                    in_tuser,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [71:0]                   out_tdata,
  input wire logic [1:0]                    out_tuser,
  input wire logic                          cfg_valid,
  input wire logic                          cfg_ready,
  input wire logic [sdsi_pkg::CfgIdxW-1:0]  cfg_index,
  input wire logic [sdsi_pkg::CfgDataW-1:0] cfg_data
);
  import sdsi_pkg::*;

  logic unused_ok;
  assign unused_ok = ^{in_tvalid, in_tready, in_tdata, in_tuser, cfg_valid, cfg_ready,
                       cfg_index, cfg_data};

  `SDSI_ASSERT_IMP(a_out_hold, out_tvalid && !out_tready, ##1 (out_tvalid && $stable(out_tdata) && $stable(out_tuser)), "stalled result changed")
  `SDSI_ASSERT_IMP(a_send_xor_done, out_tvalid, !(out_tuser[0] && out_tuser[1]), "command and final status together")
  `SDSI_ASSERT_IMP(a_no_cmd_zero, out_tvalid && !out_tuser[0], out_tdata[61:0] == 62'h0, "command fields set without a command")
  `SDSI_ASSERT_IMP(a_status_done, out_tvalid && !out_tuser[1], out_tdata[64:62] == ST_OK, "status without completion")
  `SDSI_ASSERT_IMP(a_status_range, out_tvalid, out_tdata[64:62] <= ST_BLKLEN_FAIL, "status code out of range")

endmodule

bind sd_spi_init_sequencer_top sdsi_chk u_sdsi_chk (.*);
`default_nettype wire
